FILE: hw/rtl/prime_sieve_engine_unit_defines.svh
// Assertion macros shared by the prime sieve engine RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef PRIME_SIEVE_ENGINE_UNIT_DEFINES_SVH
`define PRIME_SIEVE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pse_pkg.sv
// Package for the prime sieve engine: codes, control word layout and microcode ROM.
// No dependencies; used by prime_sieve_engine_unit.
`default_nettype none

package pse_pkg;

    localparam int MAX_LIMIT_DEF = 1024;
    localparam int NUM_W         = 11;
    localparam int FIRST_PRIME   = 2;
    localparam logic [NUM_W-1:0] LIMIT_RESET = 11'd1000;
    localparam int PC_W          = 4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ABOVE     = 2'd1,
        ST_NOT_BUILT = 2'd2,
        ST_BUILT     = 2'd3
    } status_t;

    typedef enum logic {
        OP_BUILD = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [PC_W-1:0] {
        P_QEMIT = 4'd0,
        P_BINIT = 4'd1,
        P_FILL  = 4'd2,
        P_ISQ   = 4'd3,
        P_TEST  = 4'd4,
        P_BIT   = 4'd5,
        P_CLR   = 4'd6,
        P_NEXTI = 4'd7,
        P_BEMIT = 4'd8
    } upc_t;

    typedef enum logic [1:0] {
        M_NONE  = 2'd0,
        M_FILL  = 2'd1,
        M_CLEAR = 2'd2
    } mem_op_t;

    typedef enum logic [2:0] {
        J_HOLD    = 3'd0,
        J_ZERO    = 3'd1,
        J_INC     = 3'd2,
        J_ADD_I   = 3'd3,
        J_LOAD_SQ = 3'd4
    } j_op_t;

    typedef enum logic [1:0] {
        I_HOLD = 2'd0,
        I_TWO  = 2'd1,
        I_INC  = 2'd2
    } i_op_t;

    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_ALWAYS     = 3'd1,
        C_J_LT_LIM   = 3'd2,
        C_SQ_GT_LIM  = 3'd3,
        C_BIT_CLR    = 3'd4,
        C_NXT_LE_LIM = 3'd5
    } cond_t;

    typedef enum logic [1:0] {
        E_NONE  = 2'd0,
        E_QUERY = 2'd1,
        E_BUILD = 2'd2
    } emit_t;

    typedef struct packed {
        mem_op_t mem_op;
        j_op_t   j_op;
        i_op_t   i_op;
        logic    sq_load;
        logic    rd_i;
        cond_t   cond;
        upc_t    target;
        emit_t   emit;
    } ctrl_t;

    // One control word per step. A taken condition jumps to target, otherwise
    // the step counter advances by one.
    function automatic ctrl_t micro_rom(upc_t pc);
        ctrl_t w;
        w = '{mem_op: M_NONE, j_op: J_HOLD, i_op: I_HOLD, sq_load: 1'b0,
              rd_i: 1'b0, cond: C_NEVER, target: P_QEMIT, emit: E_NONE};
        case (pc)
            P_QEMIT:
            begin
                w.emit = E_QUERY;
            end
            P_BINIT:
            begin
                w.j_op = J_ZERO;
                w.i_op = I_TWO;
            end
            P_FILL:
            begin
                w.mem_op = M_FILL;
                w.j_op   = J_INC;
                w.cond   = C_J_LT_LIM;
                w.target = P_FILL;
            end
            P_ISQ:
            begin
                w.sq_load = 1'b1;
                w.rd_i    = 1'b1;
            end
            P_TEST:
            begin
                w.j_op   = J_LOAD_SQ;
                w.cond   = C_SQ_GT_LIM;
                w.target = P_BEMIT;
            end
            P_BIT:
            begin
                w.cond   = C_BIT_CLR;
                w.target = P_NEXTI;
            end
            P_CLR:
            begin
                w.mem_op = M_CLEAR;
                w.j_op   = J_ADD_I;
                w.cond   = C_NXT_LE_LIM;
                w.target = P_CLR;
            end
            P_NEXTI:
            begin
                w.i_op   = I_INC;
                w.cond   = C_ALWAYS;
                w.target = P_ISQ;
            end
            P_BEMIT:
            begin
                w.emit = E_BUILD;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = P_BEMIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/prime_sieve_engine_unit.sv
// Prime sieve engine: microcoded sieve builder and one-bit-per-number query store.
// Depends on pse_pkg and prime_sieve_engine_unit_defines.svh.
//
// Input words arrive on the s_axis channel: tuser holds the operation (build or query)
// and tdata the number. Each input word gives exactly one output word on m_axis:
// tdata holds the primality flag and tuser the status code. The limit register is
// written through cfg_we and cfg_wdata only while the block is idle, a user's rule
// that the block does not enforce; any write clears the built flag, so queries report
// "not built" until the next build. A query reads the bit store once into a read
// register, and queries are taken one per cycle while the receiver keeps up.
// A build is run by a step counter over a microcode table and writes the bit store one
// entry per cycle in its fill and clear steps: it fills entries 0 to L, then for each
// base i from 2 with i*i <= L whose entry is set, clears multiples from i*i up to L,
// where L is the limit. The bit store has a single write port.
// After reset the limit is 1000 and no sieve is built; the store holds no valid data
// until a build has written it. When the receiver stalls, the result waits in the
// output register, one further word may be held inside, and s_axis_tready falls.
`default_nettype none

module prime_sieve_engine_unit #(
    parameter int MAX_LIMIT = pse_pkg::MAX_LIMIT_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [10:0] number
    input  wire  [0:0]  s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] is_prime
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  wire         cfg_we,
    input  wire  [10:0] cfg_wdata
);

    localparam int DEPTH = MAX_LIMIT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = ((AW > pse_pkg::NUM_W) ? AW : pse_pkg::NUM_W) + 1;
    localparam int SW    = 2 * VW;
    localparam logic [VW-1:0] MAX_V = VW'(MAX_LIMIT);

    logic [pse_pkg::NUM_W-1:0] limit_reg;
    logic                      ready_reg, ready_next;
    logic                      busy_reg, busy_next;
    pse_pkg::upc_t             pc_reg, pc_next;
    pse_pkg::ctrl_t            cw;

    logic [VW-1:0]             lim_reg, lim_next, lim_eff;
    logic [VW-1:0]             j_reg, j_next, j_step;
    logic [AW-1:0]             i_reg, i_next;
    logic [2*AW-1:0]           sq_reg;
    logic [pse_pkg::NUM_W-1:0] num_reg, num_next;
    logic [VW-1:0]             num_ext;

    logic                      mem [DEPTH];
    logic                      rd_data_reg;
    logic                      mem_we, mem_wdata, rd_en;
    logic [AW-1:0]             rd_addr;

    logic                      m_valid_reg;
    logic                      m_prime_reg, m_prime_next;
    pse_pkg::status_t          m_status_reg, m_status_next;

    logic                      in_acc, in_query, out_load, cond_hit, stepping;
    logic                      fill_wr, clr_wr, build_done, j_in_lim;

    assign cw       = pse_pkg::micro_rom(pc_reg);
    assign num_ext  = VW'(s_axis_tdata[pse_pkg::NUM_W-1:0]);
    assign lim_eff  = (VW'(limit_reg) > MAX_V) ? MAX_V : VW'(limit_reg);
    assign j_step   = j_reg + VW'(i_reg);
    assign in_query = (pse_pkg::op_t'(s_axis_tuser[0]) == pse_pkg::OP_QUERY);

    assign out_load      = busy_reg && (cw.emit != pse_pkg::E_NONE)
                           && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !busy_reg || out_load;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign stepping      = busy_reg && (cw.emit == pse_pkg::E_NONE);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_prime_reg};
    assign m_axis_tuser  = m_status_reg;

    assign fill_wr    = stepping && (cw.mem_op == pse_pkg::M_FILL);
    assign clr_wr     = stepping && (cw.mem_op == pse_pkg::M_CLEAR);
    assign build_done = out_load && (cw.emit == pse_pkg::E_BUILD) && !cfg_we;
    assign j_in_lim   = (j_reg <= lim_reg);

    always_comb
    begin
        case (cw.cond)
            pse_pkg::C_NEVER:      cond_hit = 1'b0;
            pse_pkg::C_ALWAYS:     cond_hit = 1'b1;
            pse_pkg::C_J_LT_LIM:   cond_hit = (j_reg < lim_reg);
            pse_pkg::C_SQ_GT_LIM:  cond_hit = (SW'(sq_reg) > SW'(lim_reg));
            pse_pkg::C_BIT_CLR:    cond_hit = !rd_data_reg;
            pse_pkg::C_NXT_LE_LIM: cond_hit = (j_step <= lim_reg);
            default:               cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (in_acc)
        begin
            busy_next = 1'b1;
            pc_next   = in_query ? pse_pkg::P_QEMIT : pse_pkg::P_BINIT;
        end
        else if (out_load)
        begin
            busy_next = 1'b0;
        end
        else if (stepping)
        begin
            pc_next = cond_hit ? cw.target : pse_pkg::upc_t'(pc_reg + 4'd1);
        end
    end

    always_comb
    begin
        j_next = j_reg;
        i_next = i_reg;
        if (stepping)
        begin
            case (cw.j_op)
                pse_pkg::J_HOLD:    j_next = j_reg;
                pse_pkg::J_ZERO:    j_next = '0;
                pse_pkg::J_INC:     j_next = j_reg + VW'(1);
                pse_pkg::J_ADD_I:   j_next = j_step;
                pse_pkg::J_LOAD_SQ: j_next = sq_reg[VW-1:0];
                default:            j_next = j_reg;
            endcase
            case (cw.i_op)
                pse_pkg::I_HOLD: i_next = i_reg;
                pse_pkg::I_TWO:  i_next = AW'(pse_pkg::FIRST_PRIME);
                pse_pkg::I_INC:  i_next = i_reg + AW'(1);
                default:         i_next = i_reg;
            endcase
        end
    end

    always_comb
    begin
        lim_next = lim_reg;
        num_next = num_reg;
        if (in_acc)
        begin
            num_next = s_axis_tdata[pse_pkg::NUM_W-1:0];
            if (!in_query)
            begin
                lim_next = lim_eff;
            end
        end
    end

    always_comb
    begin
        mem_we    = stepping && (cw.mem_op != pse_pkg::M_NONE);
        mem_wdata = (cw.mem_op == pse_pkg::M_FILL) && (j_reg >= VW'(pse_pkg::FIRST_PRIME));
        rd_en     = (in_acc && in_query) || (stepping && cw.rd_i);
        rd_addr   = in_acc ? num_ext[AW-1:0] : i_reg;
    end

    always_comb
    begin
        m_prime_next  = 1'b0;
        m_status_next = pse_pkg::ST_BUILT;
        if (cw.emit == pse_pkg::E_QUERY)
        begin
            if (!ready_reg)
            begin
                m_status_next = pse_pkg::ST_NOT_BUILT;
            end
            else if (VW'(num_reg) > lim_reg)
            begin
                m_status_next = pse_pkg::ST_ABOVE;
            end
            else
            begin
                m_prime_next  = rd_data_reg;
                m_status_next = pse_pkg::ST_OK;
            end
        end
    end

    always_comb
    begin
        ready_next = ready_reg;
        if (cfg_we)
        begin
            ready_next = 1'b0;
        end
        else if (out_load && (cw.emit == pse_pkg::E_BUILD))
        begin
            ready_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= pse_pkg::LIMIT_RESET;
            ready_reg   <= 1'b0;
            busy_reg    <= 1'b0;
            pc_reg      <= pse_pkg::P_QEMIT;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            ready_reg <= ready_next;
            busy_reg  <= busy_next;
            pc_reg    <= pc_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg   <= j_next;
        i_reg   <= i_next;
        lim_reg <= lim_next;
        num_reg <= num_next;
        if (stepping && cw.sq_load)
        begin
            sq_reg <= i_reg * i_reg;
        end
        if (out_load)
        begin
            m_prime_reg  <= m_prime_next;
            m_status_reg <= m_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[j_reg[AW-1:0]] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`include "prime_sieve_engine_unit_defines.svh"

    `PSE_ASSERT_IMP(a_fill_in_range, fill_wr, j_in_lim, "fill write beyond the limit")
    `PSE_ASSERT_IMP(a_clear_in_range, clr_wr, j_in_lim && (j_reg >= VW'(4)), "clear out of range")
    `PSE_ASSERT_NXT(a_build_sets_ready, build_done, ready_reg, "built flag not set")
    `PSE_ASSERT_IMP(a_no_take_mid_work, stepping, !s_axis_tready, "input taken mid build")

endmodule

`default_nettype wire
